// File: rtl/core/rtdlp_pkg.sv
package rtdlp_pkg;

  localparam int ROM_SIZE = 400;
  localparam int ROM_AW   = 9;
  localparam int CODE_W   = 24;
  localparam int CH_W     = 4;
  localparam int SCALED_W = 34;
  localparam int ROMV_W   = 31;
  localparam int TEMP_W   = 10;
  localparam int Q88_W    = 18;
  localparam int WEIGHT_W = 17;
  localparam int QDEPTH   = 2;

  localparam logic [9:0]  CODE_SCALE  = 10'd596;
  localparam int          CENTI_SCALE = 100000;
  localparam int          OPEN_CENTI  = 8070;
  localparam int          OVER_CENTI  = 19410;
  localparam logic [SCALED_W-1:0] OPEN_LIM =
    SCALED_W'(64'(OPEN_CENTI) * 64'(CENTI_SCALE));
  localparam logic [SCALED_W-1:0] OVER_LIM =
    SCALED_W'(64'(OVER_CENTI) * 64'(CENTI_SCALE));

  localparam logic signed [TEMP_W-1:0] OPEN_TEMP    = 10'sd260;
  localparam logic signed [TEMP_W-1:0] OVER_TEMP    = 10'sd250;
  localparam logic signed [TEMP_W-1:0] INDEX_OFFSET = 10'sd149;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd57617;
  localparam logic [15:0]         ENABLE_RESET = 16'h00FF;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OPEN = 2'd1;
  localparam logic [1:0] FAULT_OVER = 2'd2;

  localparam logic [1:0] REG_CH_EN  = 2'd0;
  localparam logic [1:0] REG_FLT_EN = 2'd1;
  localparam logic [1:0] REG_WEIGHT = 2'd2;

  typedef struct packed {
    logic [15:0]         ch_en;
    logic                flt_en;
    logic [WEIGHT_W-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SCALED_W-1:0] scaled;
    logic [1:0]          fault;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [TEMP_W-1:0] temp;
    logic [1:0]               fault;
    logic signed [Q88_W-1:0]  filt;
  } res_t;

  // PT100 resistance in centiohms, one entry per degree from -149.
  localparam logic [14:0] ROM_CENTI [ROM_SIZE] = '{
    15'd4014,15'd4056,15'd4097,15'd4139,15'd4180,15'd4222,15'd4263,15'd4305,15'd4346,15'd4388,
    15'd4429,15'd4470,15'd4512,15'd4553,15'd4594,15'd4636,15'd4677,15'd4718,15'd4759,15'd4800,
    15'd4842,15'd4883,15'd4924,15'd4965,15'd5006,15'd5047,15'd5088,15'd5129,15'd5170,15'd5211,
    15'd5252,15'd5293,15'd5334,15'd5375,15'd5415,15'd5456,15'd5497,15'd5538,15'd5579,15'd5619,
    15'd5660,15'd5701,15'd5741,15'd5782,15'd5823,15'd5863,15'd5904,15'd5944,15'd5985,15'd6026,
    15'd6066,15'd6107,15'd6147,15'd6188,15'd6228,15'd6268,15'd6309,15'd6349,15'd6390,15'd6430,
    15'd6470,15'd6511,15'd6551,15'd6591,15'd6631,15'd6672,15'd6712,15'd6752,15'd6792,15'd6833,
    15'd6873,15'd6913,15'd6953,15'd6993,15'd7033,15'd7073,15'd7113,15'd7153,15'd7193,15'd7233,
    15'd7273,15'd7313,15'd7353,15'd7393,15'd7433,15'd7473,15'd7513,15'd7553,15'd7593,15'd7633,
    15'd7673,15'd7712,15'd7752,15'd7792,15'd7832,15'd7872,15'd7911,15'd7951,15'd7991,15'd8031,
    15'd8070,15'd8110,15'd8150,15'd8189,15'd8229,15'd8269,15'd8308,15'd8348,15'd8387,15'd8427,
    15'd8467,15'd8506,15'd8546,15'd8585,15'd8625,15'd8664,15'd8704,15'd8743,15'd8783,15'd8822,
    15'd8862,15'd8901,15'd8940,15'd8980,15'd9019,15'd9059,15'd9098,15'd9137,15'd9177,15'd9216,
    15'd9255,15'd9295,15'd9334,15'd9373,15'd9412,15'd9452,15'd9491,15'd9530,15'd9569,15'd9609,
    15'd9648,15'd9687,15'd9726,15'd9765,15'd9804,15'd9844,15'd9883,15'd9922,15'd9961,15'd10000,
    15'd10039,15'd10078,15'd10117,15'd10156,15'd10195,15'd10234,15'd10273,15'd10312,15'd10351,
    15'd10390,
    15'd10429,15'd10468,15'd10507,15'd10546,15'd10585,15'd10624,15'd10663,15'd10702,15'd10740,
    15'd10779,
    15'd10818,15'd10857,15'd10896,15'd10935,15'd10973,15'd11012,15'd11051,15'd11090,15'd11129,
    15'd11167,
    15'd11206,15'd11245,15'd11283,15'd11322,15'd11361,15'd11400,15'd11438,15'd11477,15'd11515,
    15'd11554,
    15'd11593,15'd11631,15'd11670,15'd11708,15'd11747,15'd11786,15'd11824,15'd11863,15'd11901,
    15'd11940,
    15'd11978,15'd12017,15'd12055,15'd12094,15'd12132,15'd12171,15'd12209,15'd12247,15'd12286,
    15'd12324,
    15'd12363,15'd12401,15'd12439,15'd12478,15'd12516,15'd12554,15'd12593,15'd12631,15'd12669,
    15'd12708,
    15'd12746,15'd12784,15'd12822,15'd12861,15'd12899,15'd12937,15'd12975,15'd13013,15'd13052,
    15'd13090,
    15'd13128,15'd13166,15'd13204,15'd13242,15'd13280,15'd13318,15'd13357,15'd13395,15'd13433,
    15'd13471,
    15'd13509,15'd13547,15'd13585,15'd13623,15'd13661,15'd13699,15'd13737,15'd13775,15'd13813,
    15'd13851,
    15'd13888,15'd13926,15'd13964,15'd14002,15'd14040,15'd14078,15'd14116,15'd14154,15'd14191,
    15'd14229,
    15'd14267,15'd14305,15'd14343,15'd14380,15'd14418,15'd14456,15'd14494,15'd14531,15'd14569,
    15'd14607,
    15'd14644,15'd14682,15'd14720,15'd14757,15'd14795,15'd14833,15'd14870,15'd14908,15'd14946,
    15'd14983,
    15'd15021,15'd15058,15'd15096,15'd15133,15'd15171,15'd15208,15'd15246,15'd15283,15'd15321,
    15'd15358,
    15'd15396,15'd15433,15'd15471,15'd15508,15'd15546,15'd15583,15'd15620,15'd15658,15'd15695,
    15'd15733,
    15'd15770,15'd15807,15'd15845,15'd15882,15'd15919,15'd15956,15'd15994,15'd16031,15'd16068,
    15'd16105,
    15'd16143,15'd16180,15'd16217,15'd16254,15'd16291,15'd16329,15'd16366,15'd16403,15'd16440,
    15'd16477,
    15'd16514,15'd16551,15'd16589,15'd16626,15'd16663,15'd16700,15'd16737,15'd16774,15'd16811,
    15'd16848,
    15'd16885,15'd16922,15'd16959,15'd16996,15'd17033,15'd17070,15'd17107,15'd17143,15'd17180,
    15'd17217,
    15'd17254,15'd17291,15'd17328,15'd17365,15'd17402,15'd17438,15'd17475,15'd17512,15'd17549,
    15'd17586,
    15'd17622,15'd17659,15'd17696,15'd17733,15'd17769,15'd17806,15'd17843,15'd17879,15'd17916,
    15'd17953,
    15'd17989,15'd18026,15'd18063,15'd18099,15'd18136,15'd18172,15'd18209,15'd18246,15'd18282,
    15'd18319,
    15'd18355,15'd18392,15'd18428,15'd18465,15'd18501,15'd18538,15'd18574,15'd18611,15'd18647,
    15'd18684,
    15'd18720,15'd18756,15'd18793,15'd18829,15'd18866,15'd18902,15'd18938,15'd18975,15'd19011,
    15'd19047,
    15'd19084,15'd19120,15'd19156,15'd19192,15'd19229,15'd19265,15'd19301,15'd19337,15'd19374,
    15'd19410
  };

  // Table entry scaled by 100000; indices past the end read as the last entry.
  function automatic logic [ROMV_W-1:0] rom_scaled(input logic [ROM_AW-1:0] idx);
    logic [ROM_AW-1:0] k;
    k = (idx >= ROM_AW'(ROM_SIZE)) ? ROM_AW'(ROM_SIZE - 1) : idx;
    return ROMV_W'(ROMV_W'(ROM_CENTI[k]) * ROMV_W'(CENTI_SCALE));
  endfunction

endpackage

// File: rtl/core/rtd_code_to_temp_with_lowpass.sv
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid / tready    tdata[31:0]: channel, raw_code
// out_     master     tvalid / tready    tdata[39:0]: channel_out, table_temp, fault,
//                                        filtered_temp
// cfg_     write      cfg_we             cfg_addr selects the register, cfg_wdata the value
//
// An item waits in the front register (scaled by 596 on transfer, classified as it enters the
// two-entry queue). The back loads it when idle, then per search step reads the table and
// compares, for up to nine steps, until a compare matches or a read finds the span down to one;
// then come the filter (difference, plus multiply and add when the filter is enabled) and
// the output register. A faulted sample skips the search. Reset is synchronous and clears
// the filter memory, queue and handshakes. A stalled output holds the back; the queue fills.
module rtd_code_to_temp_with_lowpass #(
  parameter int CHANNELS      = 16,
  parameter int TABLE_ENTRIES = 400
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [3:0] channel, [27:4] raw_code, [31:28] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [3:0] channel_out, [13:4] table_temp, [15:14] fault,
                                   // [33:16] filtered_temp, [39:34] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  rtdlp_pkg::cfg_t  cfg_r;
  rtdlp_pkg::item_t push_data, pop_data;
  rtdlp_pkg::res_t  res;
  logic             push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ch_en  <= rtdlp_pkg::ENABLE_RESET;
      cfg_r.flt_en <= 1'b0;
      cfg_r.weight <= rtdlp_pkg::WEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rtdlp_pkg::REG_CH_EN:  cfg_r.ch_en  <= cfg_wdata[15:0];
        rtdlp_pkg::REG_FLT_EN: cfg_r.flt_en <= cfg_wdata[0];
        // A weight above one is held at one.
        rtdlp_pkg::REG_WEIGHT: cfg_r.weight <= (cfg_wdata > rtdlp_pkg::WEIGHT_ONE) ?
                                               rtdlp_pkg::WEIGHT_ONE : cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rtdlp_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tdata[3:0]),
    .in_code   (in_tdata[27:4]),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rtdlp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  rtdlp_back #(
    .CHANNELS      (CHANNELS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {6'b0, res.filt, res.fault, res.temp, res.ch};

`ifndef SYNTHESIS
  a_open_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:14] == rtdlp_pkg::FAULT_OPEN
    |-> $signed(out_tdata[13:4]) == rtdlp_pkg::OPEN_TEMP)
    else $error("open-wire result without its fixed temperature");
  a_over_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:14] == rtdlp_pkg::FAULT_OVER
    |-> $signed(out_tdata[13:4]) == rtdlp_pkg::OVER_TEMP)
    else $error("over-range result without its fixed temperature");
  a_unfiltered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !cfg_r.flt_en |-> out_tdata[33:24] == out_tdata[13:4]
    && out_tdata[23:16] == 8'd0)
    else $error("unfiltered result is not the table temperature in Q8.8");
  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:14] == rtdlp_pkg::FAULT_NONE
    |-> $signed(out_tdata[13:4]) >= -rtdlp_pkg::INDEX_OFFSET)
    else $error("in-range result below the first table entry");
`endif

endmodule

// File: rtl/core/rtdlp_fifo.sv
module rtdlp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rtdlp_pkg::item_t    push_data,
  output logic                full,
  input  logic                pop,
  output rtdlp_pkg::item_t    pop_data,
  output logic                empty
);

  localparam int PW = (rtdlp_pkg::QDEPTH > 1) ? $clog2(rtdlp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(rtdlp_pkg::QDEPTH + 1);

  rtdlp_pkg::item_t entry_r [rtdlp_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(rtdlp_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(rtdlp_pkg::QDEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop && !empty) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/rtdlp_front.sv
module rtdlp_front #(
  parameter int CHANNELS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtdlp_pkg::cfg_t                 cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rtdlp_pkg::CH_W-1:0]      in_ch,
  input  logic [rtdlp_pkg::CODE_W-1:0]    in_code,
  output logic                            push,
  output rtdlp_pkg::item_t                push_data,
  input  logic                            q_full
);

  logic                              v_r;
  logic [rtdlp_pkg::CH_W-1:0]        ch_r;
  logic [rtdlp_pkg::SCALED_W-1:0]    scaled_r;
  logic                              enabled;
  logic                              v_nxt;

  // Channels at or beyond CHANNELS are treated as disabled.
  assign enabled = ({1'b0, in_ch} < 5'(CHANNELS)) && cfg.ch_en[in_ch];

  assign in_ready = !v_r || !q_full;
  assign push     = v_r && !q_full;

  always_comb begin
    push_data.ch     = ch_r;
    push_data.scaled = scaled_r;
    if (scaled_r <= rtdlp_pkg::OPEN_LIM) begin
      push_data.fault = rtdlp_pkg::FAULT_OPEN;
    end else if (scaled_r >= rtdlp_pkg::OVER_LIM) begin
      push_data.fault = rtdlp_pkg::FAULT_OVER;
    end else begin
      push_data.fault = rtdlp_pkg::FAULT_NONE;
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = enabled;
    end else if (push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r     <= in_ch;
      scaled_r <= rtdlp_pkg::SCALED_W'(in_code) * rtdlp_pkg::SCALED_W'(rtdlp_pkg::CODE_SCALE);
    end
  end

endmodule

// File: rtl/core/rtdlp_back.sv
module rtdlp_back #(
  parameter int CHANNELS      = 16,
  parameter int TABLE_ENTRIES = 400
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rtdlp_pkg::cfg_t  cfg,
  input  logic             q_empty,
  input  rtdlp_pkg::item_t q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output rtdlp_pkg::res_t  out_res
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int MW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW  = rtdlp_pkg::Q88_W + 1;
  localparam int PRW = rtdlp_pkg::WEIGHT_W + 1 + DW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_FILT = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]                              state_r, state_nxt;
  logic [rtdlp_pkg::CH_W-1:0]              ch_r;
  logic [rtdlp_pkg::SCALED_W-1:0]          scaled_r;
  logic [1:0]                              fault_r;
  logic [IW-1:0]                           lo_r, hi_r, mid_r;
  logic [rtdlp_pkg::ROMV_W-1:0]            rom_q_r;
  logic signed [rtdlp_pkg::TEMP_W-1:0]     temp_r;
  logic signed [DW-1:0]                    d_r;
  logic signed [PRW-1:0]                   prod_r;
  logic signed [rtdlp_pkg::Q88_W-1:0]      q_r;
  logic signed [rtdlp_pkg::Q88_W-1:0]      mem_r [CHANNELS];
  logic                                    out_valid_r;
  rtdlp_pkg::res_t                         out_res_r;

  logic [MW-1:0]                           mem_idx;
  logic signed [rtdlp_pkg::Q88_W-1:0]      cur;
  logic signed [rtdlp_pkg::Q88_W-1:0]      y;
  logic [IW:0]                             span;
  logic [rtdlp_pkg::SCALED_W-1:0]          rom_ext;
  logic                                    out_free;
  logic                                    go_lo, go_hi;
  logic [IW-1:0]                           mid_lo, mid_hi;

  assign mem_idx  = MW'(ch_r);
  assign cur      = {temp_r, 8'b0};
  assign span     = (IW + 1)'(hi_r) - (IW + 1)'(lo_r);
  assign rom_ext  = rtdlp_pkg::SCALED_W'(rom_q_r);
  assign go_lo    = scaled_r > rom_ext;
  assign go_hi    = scaled_r < rom_ext;
  assign mid_lo   = IW'(((IW + 1)'(mid_r) + (IW + 1)'(hi_r)) >> 1);
  assign mid_hi   = IW'(((IW + 1)'(lo_r) + (IW + 1)'(mid_r)) >> 1);
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_IDLE) && !q_empty;
  // Filter: y = cur + floor(w * (last - cur) / 2^16).
  assign y        = rtdlp_pkg::Q88_W'(cur + rtdlp_pkg::Q88_W'(prod_r >>> 16));

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.fault == rtdlp_pkg::FAULT_NONE) ? ST_LOOK : ST_FILT;
        end
      end
      ST_LOOK: state_nxt = (span > (IW + 1)'(1)) ? ST_CMP : ST_FILT;
      ST_CMP:  state_nxt = (go_lo || go_hi) ? ST_LOOK : ST_FILT;
      ST_FILT: state_nxt = cfg.flt_en ? ST_MUL : ST_OUT;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        mem_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ADD) begin
        mem_r[mem_idx] <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    // The table read is registered, so each search step has a look state and a compare state.
    rom_q_r <= rtdlp_pkg::rom_scaled(rtdlp_pkg::ROM_AW'(mid_r));
    case (state_r)
      ST_IDLE: begin
        ch_r     <= q_data.ch;
        scaled_r <= q_data.scaled;
        fault_r  <= q_data.fault;
        lo_r     <= '0;
        hi_r     <= IW'(TABLE_ENTRIES - 1);
        mid_r    <= IW'((TABLE_ENTRIES - 1) / 2);
        if (q_data.fault == rtdlp_pkg::FAULT_OPEN) begin
          temp_r <= rtdlp_pkg::OPEN_TEMP;
        end else begin
          temp_r <= rtdlp_pkg::OVER_TEMP;
        end
      end
      ST_LOOK: begin
        temp_r <= $signed(rtdlp_pkg::TEMP_W'(mid_r)) - rtdlp_pkg::INDEX_OFFSET;
      end
      ST_CMP: begin
        if (go_lo) begin
          lo_r  <= mid_r;
          mid_r <= mid_lo;
        end else if (go_hi) begin
          hi_r  <= mid_r;
          mid_r <= mid_hi;
        end
      end
      ST_FILT: begin
        q_r <= cur;
        d_r <= DW'(mem_r[mem_idx]) - DW'(cur);
      end
      ST_MUL: begin
        prod_r <= $signed({1'b0, cfg.weight}) * d_r;
      end
      ST_ADD: begin
        q_r <= y;
      end
      ST_OUT: begin
        if (out_free) begin
          out_res_r.ch    <= ch_r;
          out_res_r.temp  <= temp_r;
          out_res_r.fault <= fault_r;
          out_res_r.filt  <= q_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
